// File: rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

    localparam int TYPE_W   = 2;
    localparam int START_W  = 12;
    localparam int LEN_W    = 13;
    localparam int CFG_W    = 13;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 12;
    localparam int WORD_W   = 64;

    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RESERVE = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_UNDEF   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef struct packed {
        logic clr_wr;
        logic req_load;
        logic res_bad;
        logic scan_init;
        logic fill_init;
        logic mem_rd;
        logic scan_step;
        logic fill_wr;
        logic res_nofit;
        logic res_ok;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic alloc;
        logic hit;
        logic scan_end;
        logic byte_last;
        logic fill_last;
        logic out_full;
    } stat_t;

endpackage

// File: rtl/bpa_ctrl.sv
// Controller state machine for the bitmap page allocator.
module bpa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t  cmd
);
    import bpa_pkg::*;

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_DECIDE    = 3'd2;
    localparam logic [2:0] S_SCAN_RD   = 3'd3;
    localparam logic [2:0] S_SCAN_STEP = 3'd4;
    localparam logic [2:0] S_FILL_RD   = 3'd5;
    localparam logic [2:0] S_FILL_WR   = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.bad)
                begin
                    cmd.res_bad = 1'b1;
                    state_next  = S_RESP;
                end
                else if (stat.alloc)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    cmd.fill_init = 1'b1;
                    state_next    = S_FILL_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_SCAN_STEP;
            end
            S_SCAN_STEP:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_FILL_RD;
                end
                else if (stat.scan_end)
                begin
                    cmd.res_nofit = 1'b1;
                    state_next    = S_RESP;
                end
                else if (stat.byte_last)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FILL_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.res_ok = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_FILL_RD;
                end
            end
            S_RESP:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/bpa_datapath.sv
// Datapath for the bitmap page allocator: page map memory, scan and fill logic.
module bpa_datapath
#(
    parameter int MAX_PAGES = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bpa_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic [bpa_pkg::TYPE_W-1:0]        in_type,
    input  logic [bpa_pkg::START_W-1:0]       in_start,
    input  logic [bpa_pkg::LEN_W-1:0]         in_len,
    input  bpa_pkg::cmd_t                     cmd,
    output bpa_pkg::stat_t                    stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bpa_pkg::STATUS_W-1:0]      out_status,
    output logic [bpa_pkg::PAGE_W-1:0]        out_page
);
    import bpa_pkg::*;

    localparam int NW = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW = $clog2(MAX_PAGES);
    localparam int SW = $clog2(MAX_PAGES + 1);

    logic [WORD_W-1:0] mem [NW];

    logic [CFG_W-1:0]    cfg_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [START_W-1:0]  start_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [AW-1:0]       waddr_reg;
    logic [2:0]          bsel_reg;
    logic [SW-1:0]       pos_reg;
    logic [LEN_W-1:0]    run_reg;
    logic [PW-1:0]       first_reg;
    logic [PW-1:0]       last_reg;
    logic                used_reg;
    logic [WORD_W-1:0]   rdata_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PAGE_W-1:0]   out_page_reg;

    logic [SW-1:0]       size;
    logic [7:0]          byte_bits;
    logic                hit;
    logic [PW-1:0]       hit_first;
    logic [LEN_W-1:0]    run_out;
    logic [SW-1:0]       idx;
    logic [5:0]          lo;
    logic [5:0]          hi;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   wdata;
    logic [AW-1:0]       first_w;
    logic [AW-1:0]       last_w;

    assign size = ({19'd0, cfg_reg} > 32'(MAX_PAGES)) ? SW'(MAX_PAGES) : SW'(cfg_reg);

    assign stat.bad = (len_reg == '0) || (32'(len_reg) > 32'(size))
                   || (type_reg == REQ_UNDEF)
                   || ((type_reg != REQ_ALLOC)
                       && (32'(start_reg) + 32'(len_reg) > 32'(size)));
    assign stat.alloc     = (type_reg == REQ_ALLOC);
    assign stat.clr_last  = (waddr_reg == AW'(NW - 1));
    assign stat.byte_last = (bsel_reg == 3'd7);
    assign stat.scan_end  = (32'(pos_reg) + 32'd8 >= 32'(size));
    assign stat.hit       = hit;
    assign stat.fill_last = (waddr_reg == last_w);
    assign stat.out_full  = out_valid_reg && !out_ready;

    assign byte_bits = rdata_reg[{bsel_reg, 3'b000} +: 8];

    always_comb
    begin
        hit       = 1'b0;
        hit_first = '0;
        run_out   = run_reg;
        idx       = '0;
        for (int b = 0; b < 8; b++)
        begin
            idx = pos_reg + SW'(b);
            if (!hit)
            begin
                if (byte_bits[b] || (idx >= size))
                begin
                    run_out = '0;
                end
                else
                begin
                    run_out = run_out + 1'b1;
                    if (run_out == len_reg)
                    begin
                        hit       = 1'b1;
                        hit_first = PW'(32'(idx) + 32'd1 - 32'(len_reg));
                    end
                end
            end
        end
    end

    assign first_w = AW'(first_reg >> 6);
    assign last_w  = AW'(last_reg >> 6);
    assign lo      = (waddr_reg == first_w) ? first_reg[5:0] : 6'd0;
    assign hi      = (waddr_reg == last_w) ? last_reg[5:0] : 6'd63;
    assign mask    = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (6'd63 - hi));
    assign wdata   = cmd.clr_wr ? {WORD_W{1'b1}}
                   : (used_reg ? (rdata_reg | mask) : (rdata_reg & ~mask));

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr || cmd.fill_wr)
        begin
            mem[waddr_reg] <= wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[waddr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            waddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.clr_wr)
            begin
                waddr_reg <= waddr_reg + 1'b1;
            end
            else if (cmd.scan_init)
            begin
                waddr_reg <= '0;
            end
            else if (cmd.fill_init)
            begin
                waddr_reg <= AW'(PW'(start_reg) >> 6);
            end
            else if (cmd.scan_step)
            begin
                if (hit)
                begin
                    waddr_reg <= AW'(hit_first >> 6);
                end
                else if (bsel_reg == 3'd7)
                begin
                    waddr_reg <= waddr_reg + 1'b1;
                end
            end
            else if (cmd.fill_wr)
            begin
                waddr_reg <= waddr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            type_reg  <= in_type;
            start_reg <= in_start;
            len_reg   <= in_len;
        end
        if (cmd.scan_init)
        begin
            bsel_reg <= 3'd0;
            pos_reg  <= '0;
            run_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            bsel_reg <= bsel_reg + 1'b1;
            pos_reg  <= pos_reg + SW'(8);
            run_reg  <= run_out;
        end
        if (cmd.fill_init)
        begin
            first_reg <= PW'(start_reg);
            last_reg  <= PW'(32'(start_reg) + 32'(len_reg) - 32'd1);
            used_reg  <= (type_reg == REQ_RESERVE);
        end
        else if (cmd.scan_step && hit)
        begin
            first_reg <= hit_first;
            last_reg  <= PW'(32'(hit_first) + 32'(len_reg) - 32'd1);
            used_reg  <= 1'b1;
        end
        if (cmd.res_bad)
        begin
            res_status_reg <= ST_BAD;
        end
        else if (cmd.res_nofit)
        begin
            res_status_reg <= ST_NOFIT;
        end
        else if (cmd.res_ok)
        begin
            res_status_reg <= ST_DONE;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= (res_status_reg == ST_DONE && type_reg == REQ_ALLOC)
                              ? PAGE_W'(32'(first_reg)) : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_page   = out_page_reg;

endmodule

// File: rtl/bitmap_page_allocator_core.sv
// Top level of the bitmap first-fit page allocator.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: start_page, run_length
//  m_*       out  m_tvalid/m_tready  tuser: status; tdata: page_index
//  cfg_*     in   cfg_wr_en          cfg_wr_data: page_count
//
// After reset a sweep sets the map to all used, one 64-bit word a cycle.
// Allocate reads one map word then tests it a byte a cycle, then marks the run it found
// by reading then writing each word. Free and reserve do the same for each word touched.
// One request is in flight at a time.
// A result waits in the output register while the next beat is accepted.
module bitmap_page_allocator_core
#(
    parameter int MAX_PAGES = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // start_page[11:0], run_length[24:12]
    input  logic [bpa_pkg::TYPE_W-1:0]   s_tuser,   // req_type[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // page_index[11:0]
    output logic [bpa_pkg::STATUS_W-1:0] m_tuser,   // status[1:0]
    input  logic                         cfg_wr_en,
    input  logic [bpa_pkg::CFG_W-1:0]    cfg_wr_data
);
    import bpa_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [PAGE_W-1:0] page;

    bpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_datapath #(.MAX_PAGES(MAX_PAGES)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_type     (s_tuser),
        .in_start    (s_tdata[11:0]),
        .in_len      (s_tdata[24:12]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_page    (page)
    );

    assign m_tdata = {4'd0, page};

endmodule

// File: sim/tb_top.sv
// Testbench for the bitmap first-fit page allocator: stream stimulus, predicted results, checks.
`timescale 1ns / 1ps

module tb_top;
    import bpa_pkg::*;

    localparam int NPAGES      = 4096;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;
    logic [TYPE_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;

    bit            page_used[NPAGES];
    int unsigned   map_pages;
    alloc_result_t pending_results[$];
    int            mismatches;
    int            results_seen;
    int            beats_sent;
    int            cycles;
    bit            stall_burst;
    int            stall_cycles;
    bit            rx_idle_on;
    bit            tx_idle_on;

    bitmap_page_allocator_core #(.MAX_PAGES(NPAGES)) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic alloc_result_t predict_request(logic [TYPE_W-1:0] kind,
                                                       int unsigned first, int unsigned len);
        alloc_result_t r;
        int unsigned   run;
        int unsigned   size;
        size = (map_pages > NPAGES) ? NPAGES : map_pages;
        r.status = ST_BAD;
        r.page   = '0;
        run      = 0;
        if (len != 0 && len <= size)
        begin
            if (kind == REQ_ALLOC)
            begin
                r.status = ST_NOFIT;
                for (int unsigned i = 0; i < size; i++)
                begin
                    if (page_used[i])
                        run = 0;
                    else
                    begin
                        run++;
                        if (run == len)
                        begin
                            for (int unsigned j = i + 1 - len; j <= i; j++)
                                page_used[j] = 1'b1;
                            r.status = ST_DONE;
                            r.page   = PAGE_W'(i + 1 - len);
                            break;
                        end
                    end
                end
            end
            else if (kind == REQ_FREE || kind == REQ_RESERVE)
            begin
                if (first + len <= size)
                begin
                    for (int unsigned j = first; j < first + len; j++)
                        page_used[j] = (kind == REQ_RESERVE);
                    r.status = ST_DONE;
                end
            end
        end
        return r;
    endfunction

    // receiver: random ready, with a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_cycles <= 0;
        end
        else if (stall_burst && stall_cycles < 400)
        begin
            m_tready     <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end
        else if (!rx_idle_on)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 19) == 0)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 29) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: status %0d page %0d", m_tuser,
                             m_tdata[11:0]);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.status || m_tdata !== {4'b0, exp_r.page})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected status %0d page %0d, got status %0d data %h",
                                 exp_r.status, exp_r.page, m_tuser, m_tdata);
                end
            end
        end
    end

    task automatic send_request(logic [TYPE_W-1:0] kind, int unsigned first, int unsigned len);
        int gap;
        if (tx_idle_on)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, LEN_W'(len), START_W'(first)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_request(kind, first, len));
        beats_sent++;
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_page_count(int unsigned value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        map_pages   = value;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_FREE, 0, 4096);
        send_request(REQ_ALLOC, 0, 4096);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_FREE, 4095, 1);
        send_request(REQ_FREE, 4095, 2);
        send_request(REQ_RESERVE, 100, 50);
        send_request(REQ_ALLOC, 4095, 200);
        send_request(REQ_ALLOC, 0, 4097);
        send_request(REQ_ALLOC, 0, 8191);
        send_request(REQ_UNDEF, 5, 5);
        send_request(REQ_RESERVE, 0, 4096);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_FREE, 2048, 2048);
        send_request(REQ_ALLOC, 0, 2048);
        send_request(REQ_FREE, 0, 64);
        send_request(REQ_ALLOC, 1234, 63);
    endtask

    task automatic test_page_count_extremes();
        write_page_count(1);
        send_request(REQ_FREE, 0, 1);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_ALLOC, 0, 2);
        send_request(REQ_FREE, 1, 1);
        write_page_count(0);
        send_request(REQ_FREE, 0, 1);
        send_request(REQ_ALLOC, 0, 1);
        write_page_count(8191);
        send_request(REQ_FREE, 0, 4096);
        send_request(REQ_ALLOC, 0, 4096);
        send_request(REQ_FREE, 4000, 96);
    endtask

    task automatic test_random(int count, int unsigned pages);
        int unsigned len;
        int unsigned first;
        int          pick;
        write_page_count(pages);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 80);
            first = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, pages > 0 ? pages - 1 : 0);
            if (pick < 45)
                send_request(REQ_ALLOC, $urandom_range(0, 4095), len);
            else if (pick < 75)
                send_request(REQ_FREE, first, len);
            else if (pick < 95)
                send_request(REQ_RESERVE, first, len);
            else
                send_request(REQ_UNDEF, first, len);
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        stall_burst = 1'b1;
        for (int n = 0; n < 12; n++)
            send_request(REQ_FREE, n * 8, 8);
        wait (stall_cycles >= 400);
        stall_burst = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        mismatches   = 0;
        results_seen = 0;
        beats_sent   = 0;
        cycles       = 0;
        stall_burst  = 1'b0;
        rx_idle_on   = 1'b1;
        tx_idle_on   = 1'b1;
        map_pages    = CFG_RESET;
        foreach (page_used[i])
            page_used[i] = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_page_count_extremes();
        test_backpressure();
        test_random(250, 4096);
        test_random(200, 256);
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        test_random(150, 64);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        test_random(150, 1000);
        drain_results();

        $display("Sent %0d requests, checked %0d results across page counts 0 to 8191,",
                 beats_sent, results_seen);
        $display("including all request kinds, bad ranges and a long output stall.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator_core.sv
sim/tb_top.sv
